### sv/acls_pkg.sv
package acls_pkg;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_DETECT = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    K_TUNE        = 3'd0,
    K_TUNE_DETECT = 3'd1,
    K_FOUND       = 3'd2,
    K_NOT_FOUND   = 3'd3,
    K_ABORTED     = 3'd4,
    K_IGNORED     = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SEARCH = 2'd1,
    PH_DETECT = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    CFG_MIN_FREQ    = 2'd0,
    CFG_MAX_FREQ    = 2'd1,
    CFG_STOP_WINDOW = 2'd2,
    CFG_UP_LOCK_THR = 2'd3
  } cfg_idx_e;

  localparam logic [1:0] SIG_NONE  = 2'd0;
  localparam logic [1:0] SIG_VALID = 2'd1;

  localparam logic [3:0] AFC_CODE_BELOW = 4'd7;
  localparam logic [3:0] AFC_CODE_ABOVE = 4'd8;
  localparam logic [3:0] AFC_LOW_FIRST  = 4'd1;
  localparam logic [3:0] AFC_LOW_LAST   = 4'd6;
  localparam logic [3:0] AFC_HIGH_FIRST = 4'd9;
  localparam logic [3:0] AFC_HIGH_LAST  = 4'd14;
  localparam logic [1:0] LEVEL_OK       = 2'b11;

  localparam logic [4:0] LF_NUDGE  = 5'h01;
  localparam logic [4:0] LF_DETECT = 5'h02;
  localparam logic [4:0] LF_CENTER = 5'h04;
  localparam logic [4:0] LF_LOW    = 5'h0a;
  localparam logic [4:0] LF_HIGH   = 5'h10;
  localparam logic [4:0] LF_LOCK_A = 5'h1b;
  localparam logic [4:0] LF_LOCK_B = 5'h1a;
  localparam logic [4:0] LF_FULL   = 5'h1f;

  localparam logic [7:0] LOW_RUN_LIMIT = 8'd4;
  localparam logic [15:0] FREQ_MAX     = 16'hffff;

  localparam logic [15:0] RST_MIN_FREQ    = 16'd1000;
  localparam logic [15:0] RST_MAX_FREQ    = 16'd14000;
  localparam logic [15:0] RST_STOP_WINDOW = 16'd300;
  localparam logic [7:0]  RST_UP_LOCK_THR = 8'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] start_freq;
    logic        search_up;
    logic [7:0]  afc_status;
    logic        stop_request;
    logic [1:0]  signal_type;
  } in_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [15:0] tune_freq;
  } out_t;

  typedef struct packed {
    logic [15:0] min_freq;
    logic [15:0] max_freq;
    logic [15:0] stop_window;
    logic [7:0]  up_lock_threshold;
  } cfg_t;

  typedef struct packed {
    logic [15:0] current_freq;
    logic [15:0] base_freq;
    logic [4:0]  lock_flags;
    logic [7:0]  detect_count;
    logic [7:0]  low_level_run;
    logic [15:0] candidate_freq;
    logic        direction_up;
    phase_e      phase;
  } state_t;

  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    sat_inc8 = (v == 8'hff) ? v : v + 8'd1;
  endfunction

endpackage

### sv/afc_channel_lock_search.sv
// Channel search sequencer driven by demodulator AFC status.
// Items enter on the input channel (in_valid_i, in_ready_o, in_data_i): a start
// item sets the start divider and direction, sample items carry the AFC status
// byte and the stop key, and detection answers reply to a detect request.
// Every item yields exactly one result on the output channel (out_valid_o,
// out_ready_i, out_data_o): tune, tune and detect, found, not found, aborted
// or ignored, with the divider to use.
// An accepted item is registered, passed through the step logic and written
// to the result register. One item per cycle is sustained while the receiver
// does not stall; the single pass through the step logic sets that figure.
// When the receiver stalls, the result register holds and the input register
// keeps one more item, after which in_ready_o drops until the result moves.
// Reset empties both registers, puts the search in the idle phase with all
// counters cleared and loads the default limits. Configuration is written
// through cfg_we_i, cfg_idx_i and cfg_data_i; the user must write it only
// while no item is in flight, and the block does not enforce this.
module afc_channel_lock_search (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  acls_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output acls_pkg::out_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [15:0]     cfg_data_i
);
  import acls_pkg::*;

  logic     s1_valid_q;
  in_t      s1_data_q;
  logic     out_valid_q;
  out_t     out_data_q;
  cfg_t     cfg_q;
  state_t   state_q;
  state_t   state_d;
  out_t     res_d;
  logic     advance;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  acls_step u_step (
    .st_i   (state_q),
    .item_i (s1_data_q),
    .cfg_i  (cfg_q),
    .st_o   (state_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{current_freq: '0, base_freq: '0, lock_flags: '0,
                       detect_count: '0, low_level_run: '0, candidate_freq: '0,
                       direction_up: 1'b0, phase: PH_IDLE};
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{min_freq: RST_MIN_FREQ, max_freq: RST_MAX_FREQ,
                 stop_window: RST_STOP_WINDOW, up_lock_threshold: RST_UP_LOCK_THR};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_FREQ:    cfg_q.min_freq          <= cfg_data_i;
        CFG_MAX_FREQ:    cfg_q.max_freq          <= cfg_data_i;
        CFG_STOP_WINDOW: cfg_q.stop_window       <= cfg_data_i;
        CFG_UP_LOCK_THR: cfg_q.up_lock_threshold <= cfg_data_i[7:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_ready_low_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q)
    else $error("input register refused a transfer while empty");

  a_detect_sets_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.result_kind == K_TUNE_DETECT |=> state_q.phase == PH_DETECT)
    else $error("detect request without entering the detection phase");

  a_found_ends_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (res_d.result_kind == K_FOUND || res_d.result_kind == K_NOT_FOUND ||
                res_d.result_kind == K_ABORTED) |=> state_q.phase == PH_IDLE)
    else $error("search did not end after a final result");

  a_no_freq_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_data_q.result_kind == K_NOT_FOUND ||
                    out_data_q.result_kind == K_ABORTED ||
                    out_data_q.result_kind == K_IGNORED) |-> out_data_q.tune_freq == '0)
    else $error("divider reported with a result that carries none");

endmodule

### sv/acls_step.sv
module acls_step (
  input  acls_pkg::state_t st_i,
  input  acls_pkg::in_t    item_i,
  input  acls_pkg::cfg_t   cfg_i,
  output acls_pkg::state_t st_o,
  output acls_pkg::out_t   res_o
);
  import acls_pkg::*;

  logic        up;
  logic [3:0]  code;
  logic        is_sample;
  logic        is_answer;
  logic        abort_hit;
  logic [16:0] up_limit;
  logic [15:0] down_limit;
  logic [15:0] cur_s;
  logic [4:0]  lf_s;
  logic [7:0]  dc_s;
  logic [7:0]  llr_s;
  logic [15:0] cand_s;
  logic        lock_go;
  logic [15:0] step_base;
  logic        step_end;
  logic [15:0] step_next;

  assign up        = st_i.direction_up;
  assign code      = item_i.afc_status[4:1];
  assign is_sample = (item_i.opcode == OP_SAMPLE) && (st_i.phase == PH_SEARCH);
  assign is_answer = (item_i.opcode == OP_DETECT) && (st_i.phase == PH_DETECT);

  // The stop window is checked without wrap upward and clamped at zero downward.
  assign up_limit   = {1'b0, st_i.base_freq} + {1'b0, cfg_i.stop_window};
  assign down_limit = (st_i.base_freq > cfg_i.stop_window) ?
                      st_i.base_freq - cfg_i.stop_window : '0;
  always_comb begin
    if (up) begin
      abort_hit = item_i.stop_request && ({1'b0, st_i.current_freq} > up_limit);
    end else begin
      abort_hit = item_i.stop_request && (st_i.current_freq < down_limit);
    end
  end

  always_comb begin
    cur_s  = st_i.current_freq;
    lf_s   = st_i.lock_flags;
    dc_s   = st_i.detect_count;
    cand_s = st_i.candidate_freq;
    llr_s  = '0;
    if (code == AFC_CODE_BELOW || code == AFC_CODE_ABOVE) begin
      if ((code == AFC_CODE_BELOW) == up) begin
        lf_s = LF_NUDGE;
        if (up) begin
          if (cur_s != FREQ_MAX) begin
            cur_s = cur_s + 16'd1;
          end
        end else begin
          if (cur_s != '0) begin
            cur_s = cur_s - 16'd1;
          end
        end
      end else begin
        dc_s = sat_inc8(dc_s);
        lf_s = lf_s | LF_DETECT;
      end
    end else if (code >= AFC_LOW_FIRST && code <= AFC_LOW_LAST) begin
      lf_s = lf_s | LF_LOW;
    end else if (code >= AFC_HIGH_FIRST && code <= AFC_HIGH_LAST) begin
      lf_s = lf_s | LF_HIGH;
    end else begin
      lf_s   = lf_s | LF_CENTER;
      cand_s = cur_s;
    end
    if (lf_s == LF_LOCK_A || lf_s == LF_LOCK_B) begin
      llr_s = sat_inc8(st_i.low_level_run);
      if (cand_s == '0) begin
        cand_s = cur_s;
      end
    end
    lock_go = 1'b0;
    if (item_i.afc_status[7:6] != LEVEL_OK) begin
      lf_s = '0;
      dc_s = '0;
    end else begin
      lock_go = (lf_s == LF_FULL || llr_s > LOW_RUN_LIMIT) &&
                (up ? (dc_s > cfg_i.up_lock_threshold) : (dc_s != '0));
    end
  end

  // One divider step in the search direction; the search ends at the range limits.
  assign step_base = is_sample ? cur_s : st_i.current_freq;
  always_comb begin
    if (up) begin
      step_end  = (step_base == FREQ_MAX) || (step_base >= cfg_i.max_freq);
      step_next = step_base + 16'd1;
    end else begin
      step_end  = (step_base == '0) || (step_base <= cfg_i.min_freq);
      step_next = step_base - 16'd1;
    end
  end

  always_comb begin
    st_o = st_i;
    case (item_i.opcode)
      OP_START: begin
        st_o.current_freq   = item_i.start_freq;
        st_o.base_freq      = item_i.start_freq;
        st_o.direction_up   = item_i.search_up;
        st_o.candidate_freq = '0;
        st_o.lock_flags     = '0;
        st_o.detect_count   = '0;
        st_o.low_level_run  = '0;
        st_o.phase          = PH_SEARCH;
      end
      OP_SAMPLE: begin
        if (is_sample) begin
          if (abort_hit) begin
            st_o.phase = PH_IDLE;
          end else begin
            st_o.current_freq   = step_end || lock_go ? cur_s : step_next;
            st_o.lock_flags     = lf_s;
            st_o.detect_count   = dc_s;
            st_o.low_level_run  = llr_s;
            st_o.candidate_freq = cand_s;
            st_o.phase          = lock_go ? PH_DETECT : (step_end ? PH_IDLE : PH_SEARCH);
          end
        end
      end
      OP_DETECT: begin
        if (is_answer) begin
          if (item_i.signal_type == SIG_VALID) begin
            st_o.phase = PH_IDLE;
          end else begin
            if (item_i.signal_type == SIG_NONE) begin
              st_o.low_level_run = '0;
              st_o.lock_flags    = '0;
              st_o.detect_count  = '0;
            end
            st_o.candidate_freq = '0;
            st_o.current_freq   = step_end ? st_i.current_freq : step_next;
            st_o.phase          = step_end ? PH_IDLE : PH_SEARCH;
          end
        end
      end
      default: begin
        st_o = st_i;
      end
    endcase
  end

  always_comb begin
    res_o.result_kind = K_IGNORED;
    res_o.tune_freq   = '0;
    case (item_i.opcode)
      OP_START: begin
        res_o.result_kind = K_TUNE;
        res_o.tune_freq   = item_i.start_freq;
      end
      OP_SAMPLE: begin
        if (is_sample) begin
          if (abort_hit) begin
            res_o.result_kind = K_ABORTED;
          end else if (lock_go) begin
            res_o.result_kind = K_TUNE_DETECT;
            res_o.tune_freq   = cand_s;
          end else if (step_end) begin
            res_o.result_kind = K_NOT_FOUND;
          end else begin
            res_o.result_kind = K_TUNE;
            res_o.tune_freq   = step_next;
          end
        end
      end
      OP_DETECT: begin
        if (is_answer) begin
          if (item_i.signal_type == SIG_VALID) begin
            res_o.result_kind = K_FOUND;
            res_o.tune_freq   = st_i.candidate_freq;
          end else if (step_end) begin
            res_o.result_kind = K_NOT_FOUND;
          end else begin
            res_o.result_kind = K_TUNE;
            res_o.tune_freq   = step_next;
          end
        end
      end
      default: begin
        res_o.result_kind = K_IGNORED;
      end
    endcase
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import acls_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_MIN_FREQ;
  logic [15:0] cfg_data_i = '0;

  logic [15:0] lim_lo, lim_hi, stop_span;
  logic [7:0]  up_thr;
  logic [15:0] tuned_div, origin_div, cand_div;
  logic [4:0]  lock_bits;
  logic [7:0]  hit_count, low_run;
  logic        going_up;
  phase_e      stage;

  out_t expected_results[$];
  int   send_idle_pct = 0;
  int   ready_stall_pct = 0;
  int   errors = 0;
  int   useful_items = 0;
  int   items_sent = 0;
  int   settings_used = 0;
  int   kind_seen[8];

  afc_channel_lock_search DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic flag_error(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic logic [7:0] bump(input logic [7:0] v);
    return (v == 8'hff) ? v : v + 8'd1;
  endfunction

  function automatic void search_reset();
    lim_lo = RST_MIN_FREQ;
    lim_hi = RST_MAX_FREQ;
    stop_span = RST_STOP_WINDOW;
    up_thr = RST_UP_LOCK_THR;
    tuned_div = '0;
    origin_div = '0;
    cand_div = '0;
    lock_bits = '0;
    hit_count = '0;
    low_run = '0;
    going_up = 1'b0;
    stage = PH_IDLE;
  endfunction

  function automatic out_t next_divider();
    out_t r;
    int nxt;
    nxt = going_up ? int'(tuned_div) + 1 : int'(tuned_div) - 1;
    r.tune_freq = '0;
    if (going_up ? (nxt > 65535 || nxt > int'(lim_hi)) : (nxt < 0 || nxt < int'(lim_lo))) begin
      stage = PH_IDLE;
      r.result_kind = K_NOT_FOUND;
    end else begin
      tuned_div = 16'(nxt);
      stage = PH_SEARCH;
      r.result_kind = K_TUNE;
      r.tune_freq = tuned_div;
    end
    return r;
  endfunction

  function automatic out_t search_step(input in_t it);
    out_t r;
    logic [3:0] code;
    int floor_div;
    r.result_kind = K_IGNORED;
    r.tune_freq = '0;
    if (it.opcode == OP_START) begin
      tuned_div = it.start_freq;
      origin_div = it.start_freq;
      going_up = it.search_up;
      cand_div = '0;
      lock_bits = '0;
      hit_count = '0;
      low_run = '0;
      stage = PH_SEARCH;
      r.result_kind = K_TUNE;
      r.tune_freq = tuned_div;
    end else if (it.opcode == OP_SAMPLE && stage == PH_SEARCH) begin
      code = it.afc_status[4:1];
      floor_div = (origin_div > stop_span) ? int'(origin_div) - int'(stop_span) : 0;
      if (it.stop_request && (going_up ? int'(tuned_div) > int'(origin_div) + int'(stop_span)
                                       : int'(tuned_div) < floor_div)) begin
        stage = PH_IDLE;
        r.result_kind = K_ABORTED;
      end else begin
        if (code == AFC_CODE_BELOW || code == AFC_CODE_ABOVE) begin
          if ((code == AFC_CODE_BELOW) == going_up) begin
            lock_bits = LF_NUDGE;
            if (going_up) begin
              if (tuned_div != FREQ_MAX) tuned_div = tuned_div + 16'd1;
            end else if (tuned_div != '0) begin
              tuned_div = tuned_div - 16'd1;
            end
          end else begin
            hit_count = bump(hit_count);
            lock_bits |= LF_DETECT;
          end
        end else if (code >= AFC_LOW_FIRST && code <= AFC_LOW_LAST) begin
          lock_bits |= LF_LOW;
        end else if (code >= AFC_HIGH_FIRST && code <= AFC_HIGH_LAST) begin
          lock_bits |= LF_HIGH;
        end else begin
          lock_bits |= LF_CENTER;
          cand_div = tuned_div;
        end
        if (lock_bits == LF_LOCK_A || lock_bits == LF_LOCK_B) begin
          low_run = bump(low_run);
          if (cand_div == '0) cand_div = tuned_div;
        end else begin
          low_run = '0;
        end
        if (it.afc_status[7:6] != LEVEL_OK) begin
          lock_bits = '0;
          hit_count = '0;
          r = next_divider();
        end else if ((lock_bits == LF_FULL || low_run > LOW_RUN_LIMIT) &&
                     (going_up ? hit_count > up_thr : hit_count != '0)) begin
          stage = PH_DETECT;
          r.result_kind = K_TUNE_DETECT;
          r.tune_freq = cand_div;
        end else begin
          r = next_divider();
        end
      end
    end else if (it.opcode == OP_DETECT && stage == PH_DETECT) begin
      if (it.signal_type == SIG_VALID) begin
        stage = PH_IDLE;
        r.result_kind = K_FOUND;
        r.tune_freq = cand_div;
      end else begin
        if (it.signal_type == SIG_NONE) begin
          low_run = '0;
          lock_bits = '0;
          hit_count = '0;
        end
        cand_div = '0;
        r = next_divider();
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        kind_seen[out_data_o.result_kind]++;
        if (expected_results.size() == 0) begin
          flag_error($sformatf("unexpected result kind %0d divider %0d",
                               out_data_o.result_kind, out_data_o.tune_freq));
        end else begin
          want = expected_results.pop_front();
          if (out_data_o.result_kind !== want.result_kind)
            flag_error($sformatf("result_kind %0d, expected %0d",
                                 out_data_o.result_kind, want.result_kind));
          if (out_data_o.tune_freq !== want.tune_freq)
            flag_error($sformatf("tune_freq %0d, expected %0d (kind %0d)",
                                 out_data_o.tune_freq, want.tune_freq, want.result_kind));
        end
      end
      out_ready_i <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  task automatic send_item(input in_t it);
    out_t predicted;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = search_step(it);
    expected_results.push_back(predicted);
    items_sent++;
    if (predicted.result_kind != K_IGNORED) useful_items++;
  endtask

  task automatic wait_settled();
    int guard;
    in_valid_i <= 1'b0;
    for (guard = 0; guard < 20000 && expected_results.size() != 0; guard++)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_limits(input logic [15:0] lo, input logic [15:0] hi,
                              input logic [15:0] span, input logic [7:0] thr, input int mode);
    wait_settled();
    write_reg(CFG_MIN_FREQ, lo);
    write_reg(CFG_MAX_FREQ, hi);
    write_reg(CFG_STOP_WINDOW, span);
    write_reg(CFG_UP_LOCK_THR, {8'($urandom), thr});
    cfg_we_i <= 1'b0;
    lim_lo = lo;
    lim_hi = hi;
    stop_span = span;
    up_thr = thr;
    send_idle_pct = (mode == 1) ? 74 : (mode == 3) ? 16 : 0;
    ready_stall_pct = (mode == 2) ? 74 : (mode == 3) ? 16 : 0;
    settings_used++;
  endtask

  function automatic in_t start_item(input logic [15:0] freq, input logic up);
    in_t it;
    it = in_t'($urandom);
    it.opcode = OP_START;
    it.start_freq = freq;
    it.search_up = up;
    return it;
  endfunction

  function automatic in_t sample_item(input logic [3:0] code, input logic level_ok,
                                      input logic stop);
    in_t it;
    it = in_t'($urandom);
    it.opcode = OP_SAMPLE;
    it.afc_status[4:1] = code;
    it.afc_status[7:6] = level_ok ? LEVEL_OK : 2'($urandom_range(2));
    it.stop_request = stop;
    return it;
  endfunction

  function automatic in_t answer_item(input logic [1:0] sig);
    in_t it;
    it = in_t'($urandom);
    it.opcode = OP_DETECT;
    it.signal_type = sig;
    return it;
  endfunction

  task automatic test_wrong_phase();
    in_t it;
    it = in_t'($urandom);
    it.opcode = OP_UNUSED;
    send_item(sample_item(AFC_CODE_BELOW, 1'b1, 1'b0));
    send_item(answer_item(SIG_VALID));
    send_item(it);
  endtask

  task automatic test_range_edges();
    apply_limits(16'd0, 16'hffff, 16'd300, 8'd3, 0);
    send_item(start_item(16'd0, 1'b0));
    send_item(sample_item(AFC_CODE_ABOVE, 1'b1, 1'b0));
    send_item(start_item(16'hffff, 1'b1));
    send_item(sample_item(AFC_CODE_BELOW, 1'b1, 1'b0));
    apply_limits(RST_MIN_FREQ, RST_MAX_FREQ, RST_STOP_WINDOW, RST_UP_LOCK_THR, 3);
    send_item(start_item(RST_MIN_FREQ, 1'b0));
    send_item(sample_item(4'd0, 1'b1, 1'b0));
  endtask

  task automatic test_stop_window();
    apply_limits(16'd0, 16'hffff, 16'd0, 8'd0, 0);
    send_item(start_item(16'd2000, 1'b1));
    send_item(sample_item(4'd0, 1'b0, 1'b1));
    send_item(sample_item(4'd0, 1'b1, 1'b1));
    apply_limits(16'd0, 16'hffff, 16'hffff, 8'hff, 0);
    send_item(start_item(16'd10, 1'b0));
    send_item(sample_item(4'd0, 1'b1, 1'b1));
  endtask

  task automatic test_lock_up();
    apply_limits(RST_MIN_FREQ, RST_MAX_FREQ, RST_STOP_WINDOW, 8'd1, 3);
    send_item(start_item(16'd5000, 1'b1));
    send_item(sample_item(AFC_CODE_BELOW, 1'b1, 1'b0));
    send_item(sample_item(AFC_CODE_ABOVE, 1'b1, 1'b0));
    send_item(sample_item(AFC_CODE_ABOVE, 1'b1, 1'b0));
    send_item(sample_item(4'd0, 1'b1, 1'b0));
    send_item(sample_item(4'd3, 1'b1, 1'b0));
    send_item(sample_item(4'd10, 1'b1, 1'b0));
    send_item(answer_item(2'd2));
    send_item(sample_item(4'd15, 1'b1, 1'b0));
    send_item(answer_item(SIG_NONE));
  endtask

  task automatic test_low_run_lock();
    apply_limits(RST_MIN_FREQ, RST_MAX_FREQ, RST_STOP_WINDOW, RST_UP_LOCK_THR, 0);
    send_item(start_item(16'd8000, 1'b0));
    send_item(sample_item(4'd9, 1'b1, 1'b0));
    send_item(sample_item(4'd2, 1'b1, 1'b0));
    repeat (4) send_item(sample_item(AFC_CODE_BELOW, 1'b1, 1'b0));
    send_item(answer_item(SIG_VALID));
  endtask

  function automatic in_t pick_item();
    in_t it;
    int roll;
    it = in_t'($urandom);
    roll = $urandom_range(99);
    if (roll < 6) return it;
    if (stage == PH_IDLE || roll < 9) begin
      it.opcode = OP_START;
      if ($urandom_range(4) != 0) it.start_freq = 16'($urandom_range(lim_hi, lim_lo));
    end else if (stage == PH_SEARCH) begin
      it.opcode = OP_SAMPLE;
      if ($urandom_range(7) != 0) it.afc_status[7:6] = LEVEL_OK;
      it.stop_request = ($urandom_range(19) == 0);
    end else begin
      it.opcode = OP_DETECT;
      if ($urandom_range(2) == 0) it.signal_type = SIG_VALID;
    end
    return it;
  endfunction

  task automatic run_random_searches(input int count);
    int target;
    bit paused;
    target = useful_items + count;
    paused = 1'b0;
    while (useful_items < target) begin
      send_item(pick_item());
      if (!paused && useful_items >= target - count / 2) begin
        wait_settled();
        paused = 1'b1;
      end
    end
  endtask

  task automatic test_random_settings();
    logic [15:0] lo;
    apply_limits(RST_MIN_FREQ, RST_MAX_FREQ, RST_STOP_WINDOW, RST_UP_LOCK_THR, 0);
    run_random_searches(200);
    apply_limits(16'd0, 16'hffff, 16'd0, 8'd0, 1);
    run_random_searches(200);
    apply_limits(16'd0, 16'hffff, 16'hffff, 8'hff, 2);
    run_random_searches(200);
    lo = 16'($urandom_range(20000));
    apply_limits(lo, lo + 16'($urandom_range(40000)), 16'($urandom_range(600)),
                 8'($urandom_range(6)), 3);
    run_random_searches(200);
    apply_limits(16'hffff, 16'd0, 16'($urandom), 8'($urandom), 0);
    run_random_searches(200);
    lo = 16'($urandom_range(65000));
    apply_limits(lo, lo + 16'd20, 16'd5, 8'd1, 1);
    run_random_searches(200);
    apply_limits(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), 2);
    run_random_searches(200);
    apply_limits(RST_MIN_FREQ, RST_MAX_FREQ, RST_STOP_WINDOW, 8'd2, 3);
    run_random_searches(200);
  endtask

  initial begin
    search_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_wrong_phase();
    test_range_edges();
    test_stop_window();
    test_lock_up();
    test_low_run_lock();
    test_random_settings();
    wait_settled();
    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_results.size()));
    $display("Sent %0d items under %0d limit settings and four idle patterns.",
             items_sent, settings_used);
    $display("Kinds: %0d tune, %0d detect, %0d found, %0d not found, %0d aborted, %0d ignored.",
             kind_seen[K_TUNE], kind_seen[K_TUNE_DETECT], kind_seen[K_FOUND],
             kind_seen[K_NOT_FOUND], kind_seen[K_ABORTED], kind_seen[K_IGNORED]);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end

endmodule

### files.f
sv/acls_pkg.sv
sv/acls_step.sv
sv/afc_channel_lock_search.sv
tb/tb.sv
